FILE: design/cslu_pkg.sv
package cslu_pkg;

  localparam int unsigned CH_W    = 8;
  // A run value never exceeds 2^63-1, so 63 bits hold it.
  localparam int unsigned VAL_W   = 63;
  // One hex digit appended to a 63-bit value.
  localparam int unsigned ACC_W   = VAL_W + 4;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CH_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CH_W-1:0] CH_X      = 8'h78;
  localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CH_W-1:0] BYTE_SAT  = 8'hFF;

  typedef enum logic [2:0] {
    PH_SEEK = 3'd0,
    PH_BODY = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX  = 3'd3,
    PH_OCT  = 3'd4,
    PH_DONE = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OK   = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [CH_W-1:0] data;
    kind_t           kind;
  } res_t;

  // Up to two results per character; vld1 is only set together with vld0.
  typedef struct packed {
    logic vld0;
    logic vld1;
    res_t r0;
    res_t r1;
  } dec_res_t;

  typedef struct packed {
    logic [CH_W-1:0] data;
    kind_t           kind;
    logic            last;
  } ent_t;

  // Map the character after a backslash to the byte it stands for.
  function automatic logic [CH_W-1:0] esc_map(input logic [CH_W-1:0] c);
    logic [CH_W-1:0] b;
    b = c;
    unique case (c)
      8'h61:   b = 8'd7;   // a
      8'h62:   b = 8'd8;   // b
      8'h66:   b = 8'd12;  // f
      8'h6E:   b = 8'd10;  // n
      8'h72:   b = 8'd13;  // r
      8'h74:   b = 8'd9;   // t
      8'h76:   b = 8'd11;  // v
      default: b = c;
    endcase
    return b;
  endfunction

endpackage

FILE: design/cslu_decode.sv
module cslu_decode (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [cslu_pkg::CH_W-1:0]   ch,
  output cslu_pkg::dec_res_t          res
);

  cslu_pkg::phase_t               phase_r, phase_nxt;
  logic [cslu_pkg::VAL_W-1:0]     val_r, val_nxt;
  logic                           ovf_r, ovf_nxt;

  logic                           hex_ok, oct_ok, is_dig;
  logic [3:0]                     dig;
  logic [cslu_pkg::ACC_W-1:0]     acc;
  logic                           acc_ovf;

  // What a plain body character does.
  cslu_pkg::phase_t               bc_phase;
  logic                           bc_vld;
  cslu_pkg::res_t                 bc_res;
  cslu_pkg::res_t                 run_res;

  always_comb begin
    hex_ok = 1'b0;
    dig    = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      hex_ok = 1'b1;
      dig    = ch[3:0];
    end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
      hex_ok = 1'b1;
      dig    = ch[3:0] + 4'd9;
    end
    oct_ok = (ch[7:3] == 5'b00110);
    is_dig = (phase_r == cslu_pkg::PH_HEX) ? hex_ok
           : (phase_r == cslu_pkg::PH_OCT) ? oct_ok : 1'b0;
    // Shift-append the digit; low bits are zero so OR is the add.
    if (phase_r == cslu_pkg::PH_HEX) begin
      acc = {val_r, 4'b0000} | {{(cslu_pkg::ACC_W-4){1'b0}}, dig};
    end else begin
      acc = {1'b0, val_r, 3'b000} | {{(cslu_pkg::ACC_W-3){1'b0}}, dig[2:0]};
    end
    acc_ovf = |acc[cslu_pkg::ACC_W-1:cslu_pkg::VAL_W];
  end

  always_comb begin
    bc_phase    = cslu_pkg::PH_BODY;
    bc_vld      = 1'b1;
    bc_res.data = ch;
    bc_res.kind = cslu_pkg::KIND_DATA;
    priority if (ch == cslu_pkg::CH_NUL) begin
      bc_phase    = cslu_pkg::PH_SEEK;
      bc_res.data = '0;
      bc_res.kind = cslu_pkg::KIND_ERR;
    end else if (ch == cslu_pkg::CH_QUOTE) begin
      bc_phase    = cslu_pkg::PH_DONE;
      bc_res.data = '0;
      bc_res.kind = cslu_pkg::KIND_OK;
    end else if (ch == cslu_pkg::CH_BSLASH) begin
      bc_phase = cslu_pkg::PH_ESC;
      bc_vld   = 1'b0;
    end else begin
      bc_phase = cslu_pkg::PH_BODY;
    end
    run_res.data = ovf_r ? cslu_pkg::BYTE_SAT : val_r[7:0];
    run_res.kind = cslu_pkg::KIND_DATA;
  end

  always_comb begin
    phase_nxt = phase_r;
    val_nxt   = val_r;
    ovf_nxt   = ovf_r;
    res       = '0;
    if (fire) begin
      unique case (phase_r)
        cslu_pkg::PH_BODY: begin
          phase_nxt = bc_phase;
          res.vld0  = bc_vld;
          res.r0    = bc_res;
        end
        cslu_pkg::PH_ESC: begin
          priority if (ch == cslu_pkg::CH_NUL) begin
            phase_nxt   = cslu_pkg::PH_SEEK;
            res.vld0    = 1'b1;
            res.r0.kind = cslu_pkg::KIND_ERR;
          end else if (ch == cslu_pkg::CH_X || ch == cslu_pkg::CH_ZERO) begin
            phase_nxt = (ch == cslu_pkg::CH_X) ? cslu_pkg::PH_HEX : cslu_pkg::PH_OCT;
            val_nxt   = '0;
            ovf_nxt   = 1'b0;
          end else begin
            phase_nxt   = cslu_pkg::PH_BODY;
            res.vld0    = 1'b1;
            res.r0.data = cslu_pkg::esc_map(ch);
            res.r0.kind = cslu_pkg::KIND_DATA;
          end
        end
        cslu_pkg::PH_HEX, cslu_pkg::PH_OCT: begin
          if (is_dig) begin
            // Freeze the value once it would pass 2^63-1.
            if (!ovf_r) begin
              if (acc_ovf) begin
                ovf_nxt = 1'b1;
              end else begin
                val_nxt = acc[cslu_pkg::VAL_W-1:0];
              end
            end
          end else begin
            phase_nxt = bc_phase;
            res.vld0  = 1'b1;
            res.r0    = run_res;
            res.vld1  = bc_vld;
            res.r1    = bc_res;
          end
        end
        cslu_pkg::PH_DONE: begin
          if (ch == cslu_pkg::CH_NUL) begin
            phase_nxt = cslu_pkg::PH_SEEK;
          end
        end
        default: begin
          // Seeking the opening quote.
          phase_nxt = cslu_pkg::PH_SEEK;
          if (ch == cslu_pkg::CH_NUL) begin
            res.vld0    = 1'b1;
            res.r0.kind = cslu_pkg::KIND_ERR;
          end else if (ch == cslu_pkg::CH_QUOTE) begin
            phase_nxt = cslu_pkg::PH_BODY;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cslu_pkg::PH_SEEK;
      val_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      val_r   <= val_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  a_nul_seeks: assert property (@(posedge clk) disable iff (!rst_n)
    fire && ch == cslu_pkg::CH_NUL && phase_r != cslu_pkg::PH_DONE
    |=> phase_r == cslu_pkg::PH_SEEK)
    else $error("zero byte did not return to seeking");

  a_digit_silent: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_dig |-> !res.vld0 && !res.vld1)
    else $error("digit inside a run produced a result");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_dig && ovf_r |=> ovf_r)
    else $error("overflow flag cleared inside a run");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld1 |-> res.vld0 && res.r0.kind == cslu_pkg::KIND_DATA)
    else $error("second result without a leading run byte");

endmodule

FILE: design/c_string_literal_unescaper_top.sv
// C string literal decoder. Feed one character per word on in_*; a zero byte ends a
// string. Characters before the opening quote are skipped, body bytes come out on
// out_* with escapes resolved (\a \b \f \n \r \t \v, \x hex runs, \0 octal runs that
// give the low byte of the value, or 0xFF past 2^63-1). out_tuser marks a data byte,
// an ok end (closing quote) or an error end (zero byte before the closing quote;
// drop that string's bytes). Each character is decoded in the cycle it is accepted,
// so the block takes one character per cycle; the output side delivers one word per
// cycle while out_tready is high, and a character that ends a digit run yields two
// words. A four-entry output queue decouples the sides; in_tready is low while fewer
// than two entries are free. out_tlast marks the final word caused by one character.
module c_string_literal_unescaper_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] ch
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [1:0] kind
  output logic       out_tlast
);

  logic                         in_fire, out_fire;
  cslu_pkg::dec_res_t           dec;
  cslu_pkg::ent_t               ent_r [cslu_pkg::Q_DEPTH];
  cslu_pkg::ent_t               e0, e1;
  logic [cslu_pkg::Q_AW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [cslu_pkg::Q_AW-1:0]    wr_ptr_p1;
  logic [cslu_pkg::Q_CW-1:0]    cnt_r, cnt_nxt;
  logic [cslu_pkg::Q_CW-1:0]    n_push;

  // Hold off input while in reset.
  assign in_tready = rst_n && (cnt_r <= cslu_pkg::Q_CW'(cslu_pkg::Q_DEPTH - 2));
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;

  cslu_decode u_dec (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (in_fire),
    .ch    (in_tdata),
    .res   (dec)
  );

  always_comb begin
    e0.data   = dec.r0.data;
    e0.kind   = dec.r0.kind;
    e0.last   = !dec.vld1;
    e1.data   = dec.r1.data;
    e1.kind   = dec.r1.kind;
    e1.last   = 1'b1;
    n_push    = cslu_pkg::Q_CW'(dec.vld0) + cslu_pkg::Q_CW'(dec.vld1);
    wr_ptr_p1 = wr_ptr_r + 1'b1;
    wr_ptr_nxt = wr_ptr_r + n_push[cslu_pkg::Q_AW-1:0];
    rd_ptr_nxt = rd_ptr_r + cslu_pkg::Q_AW'(out_fire);
    cnt_nxt    = cnt_r + n_push - cslu_pkg::Q_CW'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dec.vld0) begin
      ent_r[wr_ptr_r] <= e0;
    end
    if (dec.vld1) begin
      ent_r[wr_ptr_p1] <= e1;
    end
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = ent_r[rd_ptr_r].data;
  assign out_tuser  = ent_r[rd_ptr_r].kind;
  assign out_tlast  = ent_r[rd_ptr_r].last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cslu_pkg::Q_CW'(cslu_pkg::Q_DEPTH))
    else $error("output queue overfilled");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == cslu_pkg::Q_CW'({1'b0, wr_ptr_r - rd_ptr_r})
    || cnt_r == cslu_pkg::Q_CW'(cslu_pkg::Q_DEPTH))
    else $error("queue count out of step with pointers");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    dec.vld0 |-> in_fire && cnt_r <= cslu_pkg::Q_CW'(cslu_pkg::Q_DEPTH - 2))
    else $error("result pushed without an accepted word or room");

endmodule

FILE: verif/tb_c_string_literal_unescaper_top.sv
`timescale 1ns / 1ps

module tb_c_string_literal_unescaper_top;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_CHARS = 1200;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned HOLD_AFTER   = 400;
  localparam logic [63:0] RUN_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;

  // Tracks the decoder state and the words it has yet to deliver.
  class unescape_checker;
    cslu_pkg::phase_t phase;
    logic [63:0]      run_value;
    bit               run_ovf;
    cslu_pkg::ent_t   expected_words[$];
    int               errors;

    function new();
      phase     = cslu_pkg::PH_SEEK;
      run_value = '0;
      run_ovf   = 1'b0;
      errors    = 0;
    endfunction

    function void push_word(logic [7:0] b, cslu_pkg::kind_t k);
      cslu_pkg::ent_t e;
      e.data = b;
      e.kind = k;
      e.last = 1'b0;
      expected_words.push_back(e);
    endfunction

    function int digit_value(logic [7:0] c, int base);
      int d;
      d = -1;
      if (c >= "0" && c <= "9") d = int'(c) - int'(cslu_pkg::CH_ZERO);
      else if (c >= "a" && c <= "f") d = int'(c) - int'(8'h61) + 10;
      else if (c >= "A" && c <= "F") d = int'(c) - int'(8'h41) + 10;
      if (d >= base) d = -1;
      return d;
    endfunction

    function void body_char(logic [7:0] c);
      if (c == cslu_pkg::CH_NUL) begin
        phase = cslu_pkg::PH_SEEK;
        push_word(8'h00, cslu_pkg::KIND_ERR);
      end else if (c == cslu_pkg::CH_QUOTE) begin
        phase = cslu_pkg::PH_DONE;
        push_word(8'h00, cslu_pkg::KIND_OK);
      end else if (c == cslu_pkg::CH_BSLASH) begin
        phase = cslu_pkg::PH_ESC;
      end else begin
        push_word(c, cslu_pkg::KIND_DATA);
      end
    endfunction

    function logic [7:0] escape_byte(logic [7:0] c);
      logic [7:0] b;
      b = c;
      case (c)
        "a":     b = 8'd7;
        "b":     b = 8'd8;
        "f":     b = 8'd12;
        "n":     b = 8'd10;
        "r":     b = 8'd13;
        "t":     b = 8'd9;
        "v":     b = 8'd11;
        default: b = c;
      endcase
      return b;
    endfunction

    // Advance the state by one accepted character and queue the words it causes.
    function void note_char(logic [7:0] c);
      int          before_n;
      int          base;
      int          d;
      logic [63:0] dv;
      logic [63:0] bv;
      before_n = expected_words.size();
      case (phase)
        cslu_pkg::PH_SEEK: begin
          if (c == cslu_pkg::CH_NUL) push_word(8'h00, cslu_pkg::KIND_ERR);
          else if (c == cslu_pkg::CH_QUOTE) phase = cslu_pkg::PH_BODY;
        end
        cslu_pkg::PH_DONE: begin
          if (c == cslu_pkg::CH_NUL) phase = cslu_pkg::PH_SEEK;
        end
        cslu_pkg::PH_HEX, cslu_pkg::PH_OCT: begin
          base = (phase == cslu_pkg::PH_HEX) ? 16 : 8;
          d = digit_value(c, base);
          if (d >= 0) begin
            dv = 64'(d);
            bv = 64'(base);
            if (!run_ovf) begin
              if (run_value > (RUN_MAX - dv) / bv) run_ovf = 1'b1;
              else run_value = run_value * bv + dv;
            end
          end else begin
            push_word(run_ovf ? cslu_pkg::BYTE_SAT : run_value[7:0], cslu_pkg::KIND_DATA);
            phase = cslu_pkg::PH_BODY;
            body_char(c);
          end
        end
        cslu_pkg::PH_ESC: begin
          if (c == cslu_pkg::CH_NUL) begin
            phase = cslu_pkg::PH_SEEK;
            push_word(8'h00, cslu_pkg::KIND_ERR);
          end else if (c == cslu_pkg::CH_X || c == cslu_pkg::CH_ZERO) begin
            phase     = (c == cslu_pkg::CH_X) ? cslu_pkg::PH_HEX : cslu_pkg::PH_OCT;
            run_value = '0;
            run_ovf   = 1'b0;
          end else begin
            phase = cslu_pkg::PH_BODY;
            push_word(escape_byte(c), cslu_pkg::KIND_DATA);
          end
        end
        cslu_pkg::PH_BODY: body_char(c);
        default: phase = cslu_pkg::PH_SEEK;
      endcase
      if (expected_words.size() > before_n)
        expected_words[expected_words.size() - 1].last = 1'b1;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_word(logic [7:0] d, logic [1:0] k, logic l);
      cslu_pkg::ent_t e;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word byte=%02h kind=%0d last=%0b", d, k, l));
      end else begin
        e = expected_words.pop_front();
        if (d !== e.data)
          report($sformatf("byte %02h, expected %02h", d, e.data));
        if (k !== e.kind)
          report($sformatf("kind %0d, expected %0d", k, e.kind));
        if (l !== e.last)
          report($sformatf("last %0b, expected %0b", l, e.last));
      end
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic       out_tlast;

  c_string_literal_unescaper_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  unescape_checker checker_h;
  logic [7:0]      char_q[$];
  int unsigned     chars_sent;
  int unsigned     cycle_count;
  int unsigned     tx_quiet;
  int unsigned     rx_quiet;
  bit              hold_rx;

  string hex_digits = "0123456789abcdefABCDEF";
  string esc_letters = "abfnrtv";

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int unsigned draw_gap(ref int unsigned quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) quiet = $urandom_range(20, 60);
    return $urandom_range(0, 10);
  endfunction

  task automatic send_char(logic [7:0] c);
    int unsigned gap;
    gap = draw_gap(tx_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    checker_h.note_char(c);
    chars_sent++;
  endtask

  // Any byte except the zero byte, the quote and the backslash.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == cslu_pkg::CH_QUOTE || c == cslu_pkg::CH_BSLASH);
    return c;
  endfunction

  function automatic void add_run(bit is_hex);
    int unsigned n;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 25) : $urandom_range(0, 4);
    char_q.push_back(cslu_pkg::CH_BSLASH);
    char_q.push_back(is_hex ? cslu_pkg::CH_X : cslu_pkg::CH_ZERO);
    repeat (n) begin
      if (is_hex) char_q.push_back(hex_digits[$urandom_range(0, 21)]);
      else char_q.push_back(8'(cslu_pkg::CH_ZERO + $urandom_range(0, 7)));
    end
  endfunction

  function automatic void add_body_piece();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      char_q.push_back(plain_char());
    end else if (r < 60) begin
      char_q.push_back(cslu_pkg::CH_BSLASH);
      if ($urandom_range(0, 1) == 0) char_q.push_back(esc_letters[$urandom_range(0, 6)]);
      else char_q.push_back(8'($urandom_range(1, 255)));
    end else if (r < 75) begin
      add_run(1'b1);
    end else if (r < 90) begin
      add_run(1'b0);
    end else begin
      char_q.push_back(cslu_pkg::CH_BSLASH);
      char_q.push_back($urandom_range(0, 1) ? cslu_pkg::CH_QUOTE : cslu_pkg::CH_BSLASH);
    end
  endfunction

  // Mostly complete literals, some cut short by the zero byte, some raw noise.
  function automatic void add_random_string();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 90) begin
      repeat ($urandom_range(0, 3)) begin
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == cslu_pkg::CH_QUOTE);
        char_q.push_back(c);
      end
      char_q.push_back(cslu_pkg::CH_QUOTE);
      repeat ($urandom_range(0, 12)) add_body_piece();
      if (r < 75) begin
        char_q.push_back(cslu_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 2)) char_q.push_back(8'($urandom_range(1, 255)));
      end else begin
        case ($urandom_range(0, 2))
          0: char_q.push_back(cslu_pkg::CH_BSLASH);
          1: begin
            char_q.push_back(cslu_pkg::CH_BSLASH);
            char_q.push_back(cslu_pkg::CH_X);
            char_q.push_back(hex_digits[$urandom_range(0, 21)]);
          end
          default: ;
        endcase
      end
      char_q.push_back(cslu_pkg::CH_NUL);
    end else begin
      repeat ($urandom_range(1, 8)) char_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cycle_count = 0;
    chars_sent  = 0;
    tx_quiet    = 0;
    rx_quiet    = 0;
    hold_rx     = 1'b0;
    checker_h   = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero while seeking, skipped text, escapes, runs ended by quote/zero,
    // zero right after a backslash
    char_q = '{cslu_pkg::CH_NUL, "k", cslu_pkg::CH_QUOTE, cslu_pkg::CH_BSLASH, "n",
               cslu_pkg::CH_BSLASH, cslu_pkg::CH_X, "4", "1",
               cslu_pkg::CH_BSLASH, cslu_pkg::CH_ZERO, cslu_pkg::CH_QUOTE, "z",
               cslu_pkg::CH_NUL,
               cslu_pkg::CH_QUOTE, 8'hFF, 8'h01, cslu_pkg::CH_BSLASH, cslu_pkg::CH_BSLASH,
               cslu_pkg::CH_BSLASH, cslu_pkg::CH_X, "F",
               cslu_pkg::CH_NUL, cslu_pkg::CH_QUOTE, cslu_pkg::CH_BSLASH,
               cslu_pkg::CH_NUL};
    while (char_q.size() > 0) send_char(char_q.pop_front());

    while (chars_sent < RANDOM_CHARS + 26) begin
      add_random_string();
      while (char_q.size() > 0) send_char(char_q.pop_front());
    end
    in_tvalid <= 1'b0;

    while (checker_h.expected_words.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (checker_h.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    wait (rst_n);
    forever begin
      int unsigned stall;
      stall = draw_gap(rx_quiet);
      if (stall > 0 || hold_rx) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_rx) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      checker_h.check_word(out_tdata, out_tuser, out_tlast);
    end
  end

  // Hold off the receiver long enough for the output queue to fill and stall input.
  initial begin
    wait (chars_sent >= HOLD_AFTER);
    @(posedge clk);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx = 1'b0;
  end

endmodule

FILE: sim.f
design/cslu_pkg.sv
design/cslu_decode.sv
design/c_string_literal_unescaper_top.sv
verif/tb_c_string_literal_unescaper_top.sv
